// File: src/uts_pkg.sv
// ----------------------------------------------------------------------------
// uts_pkg
// Shared types, constants and character-class functions for the UTF-8 text
// sanitizer.
// ----------------------------------------------------------------------------
package uts_pkg;

  // Result slots per job (one more than used): an input byte yields at most an
  // optional space plus three UTF-8 bytes (the allowed set never needs four).
  localparam int unsigned JOB_BYTES = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  SPACE_BYTE   = 8'h20;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_MIN_2B    = 21'h000080;
  localparam logic [20:0] CP_MIN_3B    = 21'h000800;
  localparam logic [20:0] CP_MIN_4B    = 21'h010000;
  localparam logic [20:0] CP_MAX_1B    = 21'h00007F;
  localparam logic [20:0] CP_MAX_2B    = 21'h0007FF;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;
  localparam logic [20:0] RSQUO        = 21'h002019;
  localparam logic [20:0] RDQUO        = 21'h00201D;
  localparam logic [20:0] LSQUO        = 21'h002018;
  localparam logic [20:0] LDQUO        = 21'h00201C;
  localparam logic [20:0] ELLIPSIS     = 21'h002026;
  localparam logic [20:0] INV_EXCL     = 21'h0000A1;
  localparam logic [20:0] INV_QUEST    = 21'h0000BF;
  localparam logic [20:0] LAT1_LO      = 21'h0000C0;
  localparam logic [20:0] LAT1_TIMES   = 21'h0000D7;
  localparam logic [20:0] LAT1_DIVIDE  = 21'h0000F7;
  localparam logic [20:0] LATB_HI      = 21'h00024F;
  localparam logic [20:0] COMB_LO      = 21'h000300;
  localparam logic [20:0] COMB_HI      = 21'h00036F;
  localparam logic [20:0] LATX_LO      = 21'h001E00;
  localparam logic [20:0] LATX_HI      = 21'h001EFF;

  // One queued unit of output work: the result bytes of one input byte.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;    // 1..4 results
    logic                      present;  // 0 for an end-only marker
    logic                      text_end;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } job_push_t;

  function automatic logic is_closing(input logic [20:0] c);
    logic r;
    r = 1'b0;
    if (c[20:8] == 13'd0) begin
      case (c[7:0])
        ".", ",", ";", ":", "!", "?", ")", "/", "%": r = 1'b1;
        default: r = 1'b0;
      endcase
    end
    if (c == RSQUO || c == RDQUO) r = 1'b1;
    return r;
  endfunction

  function automatic logic is_allowed(input logic [20:0] c);
    logic r;
    r = 1'b0;
    if (c[20:8] == 13'd0) begin
      case (c[7:0])
        ".", ",", ";", ":", "!", "?", "'", "\"", "-", "(", ")", "/",
        "@", "#", "&", "+", "%": r = 1'b1;
        default: r = ((c[7:0] >= "0") && (c[7:0] <= "9")) ||
                     ((c[7:0] >= "A") && (c[7:0] <= "Z")) ||
                     ((c[7:0] >= "a") && (c[7:0] <= "z"));
      endcase
    end
    if (c == INV_EXCL || c == INV_QUEST || c == LSQUO || c == RSQUO ||
        c == LDQUO || c == RDQUO || c == ELLIPSIS) r = 1'b1;
    if (c >= LAT1_LO && c <= LATB_HI && c != LAT1_TIMES && c != LAT1_DIVIDE) r = 1'b1;
    if (c >= COMB_LO && c <= COMB_HI) r = 1'b1;
    if (c >= LATX_LO && c <= LATX_HI) r = 1'b1;
    return r;
  endfunction

endpackage

// File: src/uts_in_if.sv
// ----------------------------------------------------------------------------
// uts_in_if
// Input byte channel: valid/ready handshake with the raw byte and end flag.
// ----------------------------------------------------------------------------
interface uts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_last;

  modport source (output valid, output in_byte, output text_last, input ready);
  modport sink   (input valid, input in_byte, input text_last, output ready);
endinterface

// File: src/uts_out_if.sv
// ----------------------------------------------------------------------------
// uts_out_if
// Output byte channel: valid/ready handshake with one sanitized result.
// ----------------------------------------------------------------------------
interface uts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output byte_present,
                  output run_last, output text_end, input ready);
  modport sink   (input valid, input out_byte, input byte_present,
                  input run_last, input text_end, output ready);
endinterface

// File: src/utf8_text_sanitizer_top.sv
// ----------------------------------------------------------------------------
// utf8_text_sanitizer_top
// UTF-8 text sanitizer: strict decode, allowed-set filter, gap-to-space
// folding and re-encode.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle whenever its two-entry job queue
// has room, and gives one output byte per cycle, while work is queued and the
// receiver is ready, from a registered output stage. Each input byte yields
// zero to four results (a folded space plus up to three UTF-8 bytes, or one
// end marker on the final byte of a text), so the sustained rate is set by
// the serializer; a byte with no results is not queued. The first result of
// a byte is written into the job queue and then into the output register,
// where it waits until it is taken. The decoder resolves a whole byte in the
// cycle it is taken.
// ----------------------------------------------------------------------------
module utf8_text_sanitizer_top
  import uts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  uts_in_if.sink    text_in,
  uts_out_if.source text_out
);

  job_push_t push;
  logic      queue_full;
  logic      pop;
  logic      head_valid;
  job_t      head;

  uts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .queue_full (queue_full),
    .push       (push)
  );

  uts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  uts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .text_out   (text_out)
  );

endmodule

// File: src/uts_front.sv
// ----------------------------------------------------------------------------
// uts_front
// Decoder front end: validates UTF-8, tracks gap state and builds the full
// result byte list of each input byte combinationally, in the cycle it is taken.
// ----------------------------------------------------------------------------
module uts_front
  import uts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  uts_in_if.sink     text_in,
  input  logic       queue_full,
  output job_push_t  push
);

  logic        gap;
  logic        emitted;
  logic [1:0]  need;
  logic [1:0]  seen;
  logic [20:0] part;

  logic        gap_next;
  logic        emitted_next;
  logic [1:0]  need_next;
  logic [1:0]  seen_next;
  logic [20:0] part_next;

  logic        accept;
  logic [7:0]  b;
  logic [1:0]  seen_inc;
  logic [20:0] acc;
  logic        seq_ok;
  logic        cp_take;
  logic [20:0] cp;
  logic        space;
  logic [2:0][7:0] enc;
  logic [1:0]  enc_n;
  job_t        job;

  assign text_in.ready = !queue_full;
  assign accept        = text_in.valid && text_in.ready;
  assign b             = text_in.in_byte;
  assign seen_inc      = seen + 2'd1;
  assign acc           = {part[14:0], b[5:0]};

  // Check a completed multi-byte sequence against its length
  always_comb begin
    case (need)
      2'd1:    seq_ok = acc >= CP_MIN_2B;
      2'd2:    seq_ok = (acc >= CP_MIN_3B) && !((acc >= SURR_LO) && (acc <= SURR_HI));
      2'd3:    seq_ok = (acc >= CP_MIN_4B) && (acc <= CP_MAX);
      default: seq_ok = 1'b0;
    endcase
  end

  // Decode the byte, update the sequence state and build the result list
  always_comb begin
    gap_next     = gap;
    emitted_next = emitted;
    need_next    = need;
    seen_next    = seen;
    part_next    = part;
    cp_take      = 1'b0;
    cp           = {13'd0, b};
    space        = 1'b0;
    enc          = '0;
    enc_n        = 2'd0;

    if (need != 2'd0 && b[7:6] == 2'b10) begin
      // continuation of an open sequence
      part_next = acc;
      seen_next = seen_inc;
      if (seen_inc >= need) begin
        need_next = 2'd0;
        seen_next = 2'd0;
        part_next = '0;
        if (seq_ok) begin
          cp_take = 1'b1;
          cp      = acc;
        end else begin
          gap_next = emitted;
        end
      end
    end else begin
      // a broken sequence fails, then the byte is taken as a new lead
      if (need != 2'd0) begin
        gap_next  = emitted;
        need_next = 2'd0;
        seen_next = 2'd0;
        part_next = '0;
      end
      if (!b[7]) begin
        cp_take = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        need_next = 2'd1;
        seen_next = 2'd0;
        part_next = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        need_next = 2'd2;
        seen_next = 2'd0;
        part_next = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        need_next = 2'd3;
        seen_next = 2'd0;
        part_next = {18'd0, b[2:0]};
      end else begin
        gap_next = emitted;
      end
    end

    // Filter against the allowed set and re-encode (at most three bytes)
    if (cp_take) begin
      if (!is_allowed(cp)) begin
        gap_next = emitted;
      end else begin
        space = gap_next && !is_closing(cp);
        if (cp <= CP_MAX_1B) begin
          enc[0] = cp[7:0];
          enc_n  = 2'd1;
        end else if (cp <= CP_MAX_2B) begin
          enc[0] = {3'b110, cp[10:6]};
          enc[1] = {2'b10, cp[5:0]};
          enc_n  = 2'd2;
        end else begin
          enc[0] = {4'b1110, cp[15:12]};
          enc[1] = {2'b10, cp[11:6]};
          enc[2] = {2'b10, cp[5:0]};
          enc_n  = 2'd3;
        end
        gap_next     = 1'b0;
        emitted_next = 1'b1;
      end
    end

    job.bytes[0] = space ? SPACE_BYTE : enc[0];
    job.bytes[1] = space ? enc[0] : enc[1];
    job.bytes[2] = space ? enc[1] : enc[2];
    job.bytes[3] = space ? enc[2] : 8'd0;
    job.bytes[4] = 8'd0;
    job.count    = {1'b0, enc_n} + {2'd0, space};
    job.present  = 1'b1;
    job.text_end = 1'b0;

    // End of text: mark the last result, or send a marker; clear all state
    if (text_in.text_last) begin
      job.text_end = 1'b1;
      if (job.count == 3'd0) begin
        job.count   = 3'd1;
        job.present = 1'b0;
        job.bytes   = '0;
      end
      gap_next     = 1'b0;
      emitted_next = 1'b0;
      need_next    = 2'd0;
      seen_next    = 2'd0;
      part_next    = '0;
    end
  end

  assign push.push = accept && (job.count != 3'd0);
  assign push.job  = job;

  // Advance decoder state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      gap     <= 1'b0;
      emitted <= 1'b0;
      need    <= 2'd0;
      seen    <= 2'd0;
      part    <= '0;
    end else if (accept) begin
      gap     <= gap_next;
      emitted <= emitted_next;
      need    <= need_next;
      seen    <= seen_next;
      part    <= part_next;
    end
  end

endmodule

// File: src/uts_queue.sv
// ----------------------------------------------------------------------------
// uts_queue
// Two-entry job queue between the decoder front end and the byte serializer.
// ----------------------------------------------------------------------------
module uts_queue
  import uts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_push_t push,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head
);

  job_t       entries [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = fill == 2'(QUEUE_DEPTH);
  assign head_valid = fill != 2'd0;
  assign head       = entries[rd_ptr];

  // Hold job payloads
  always_ff @(posedge clk) begin
    if (push.push) begin
      entries[wr_ptr] <= push.job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push.push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)       rd_ptr <= rd_ptr + 1'b1;
      if (push.push && !pop)      fill <= fill + 2'd1;
      else if (!push.push && pop) fill <= fill - 2'd1;
    end
  end

endmodule

// File: src/uts_back.sv
// ----------------------------------------------------------------------------
// uts_back
// Byte serializer: walks the head job one byte per cycle into the output
// register, unless that register holds a byte the receiver has not taken.
// ----------------------------------------------------------------------------
module uts_back
  import uts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop,
  uts_out_if.source text_out
);

  logic [2:0] idx;
  logic       load;
  logic       final_byte;
  logic [7:0] sel_byte;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       text_end;

  assign load       = head_valid && (!out_valid || text_out.ready);
  assign final_byte = (idx + 3'd1) == head.count;
  assign pop        = load && final_byte;

  // Pick the current byte of the head job
  always_comb begin
    case (idx)
      3'd0:    sel_byte = head.bytes[0];
      3'd1:    sel_byte = head.bytes[1];
      3'd2:    sel_byte = head.bytes[2];
      3'd3:    sel_byte = head.bytes[3];
      3'd4:    sel_byte = head.bytes[4];
      default: sel_byte = 8'd0;
    endcase
  end

  // Hold the output register; advance the byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? 3'd0 : idx + 3'd1;
      end else if (text_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= sel_byte;
      byte_present <= head.present;
      run_last     <= final_byte;
      text_end     <= final_byte && head.text_end;
    end
  end

  assign text_out.valid        = out_valid;
  assign text_out.out_byte     = out_byte;
  assign text_out.byte_present = byte_present;
  assign text_out.run_last     = run_last;
  assign text_out.text_end     = text_end;

endmodule

// File: sim/tb_utf8_text_sanitizer_top.sv
// ----------------------------------------------------------------------------
// tb_utf8_text_sanitizer_top
// Self-checking bench for the UTF-8 text sanitizer. A short directed text
// exercises the decoder corner cases. Random texts follow, mostly well-formed
// UTF-8 with some broken, overlong, surrogate and out-of-range sequences
// mixed in. Every accepted input byte is run through a local model of the
// decoder and gap folding. The bytes it predicts are compared in order
// against the output channel, while both sides of the handshake idle at
// random.
// ----------------------------------------------------------------------------
module tb_utf8_text_sanitizer_top;
  import uts_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS     = 200;
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam string       ALLOWED_PUNCT    = ".,;:!?'\"-()/@#&+%";
  localparam string       CLOSING_PUNCT    = ".,;:!?)/%";

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       run_last;
    logic       text_end;
  } text_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Values driven onto the channels
  logic       drv_valid = 1'b0;
  logic [7:0] drv_byte  = 8'h00;
  logic       drv_last  = 1'b0;
  logic       rcv_ready = 1'b0;

  uts_in_if  in_ch();
  uts_out_if out_ch();

  assign in_ch.valid     = drv_valid;
  assign in_ch.in_byte   = drv_byte;
  assign in_ch.text_last = drv_last;
  assign out_ch.ready    = rcv_ready;

  utf8_text_sanitizer_top uut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (in_ch),
    .text_out (out_ch)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores
  text_byte_t   text_bytes_q[$];
  text_result_t owed_results_q[$];
  logic [7:0]   build_q[$];

  // Local copy of the decoder state
  logic        gap_owed;
  logic        wrote_any;
  logic [1:0]  cont_need;
  logic [1:0]  cont_seen;
  logic [20:0] cp_acc;
  logic [7:0]  seq_lead;
  logic [7:0]  step_out[$];

  // Bookkeeping
  int unsigned err_count     = 0;
  int unsigned bytes_in      = 0;
  int unsigned results_out   = 0;
  int unsigned texts_done    = 0;
  int unsigned spaces_owed   = 0;
  int unsigned markers_owed  = 0;
  int unsigned idle_cycles   = 0;
  logic        in_took       = 1'b0;
  logic        hold_req      = 1'b0;

  // Sender and receiver pacing
  int unsigned send_gap      = 0;
  int unsigned burst_left    = 0;
  int unsigned long_hold_left = 0;
  logic        long_hold_done = 1'b0;
  rx_mode_t    rx_mode       = RX_OPEN;
  int unsigned rx_mode_left  = 40;
  int unsigned rx_phase      = 0;

  // --------------------------------------------------------------------------
  // Character classes
  // --------------------------------------------------------------------------
  function automatic bit cp_allowed(input logic [20:0] c);
    bit hit;
    hit = 1'b0;
    if (c <= CP_MAX_1B) begin
      hit = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      for (int i = 0; i < ALLOWED_PUNCT.len(); i++) begin
        if (ALLOWED_PUNCT[i] == c[7:0]) hit = 1'b1;
      end
    end else begin
      hit = c == INV_EXCL || c == INV_QUEST || c == LSQUO || c == RSQUO ||
            c == LDQUO || c == RDQUO || c == ELLIPSIS ||
            (c >= LAT1_LO && c <= LATB_HI && c != LAT1_TIMES && c != LAT1_DIVIDE) ||
            (c >= COMB_LO && c <= COMB_HI) || (c >= LATX_LO && c <= LATX_HI);
    end
    return hit;
  endfunction

  function automatic bit cp_closing(input logic [20:0] c);
    bit hit;
    hit = (c == RSQUO) || (c == RDQUO);
    if (c <= CP_MAX_1B) begin
      for (int i = 0; i < CLOSING_PUNCT.len(); i++) begin
        if (CLOSING_PUNCT[i] == c[7:0]) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic void close_seq();
    cont_need = 2'd0;
    cont_seen = 2'd0;
    cp_acc    = 21'd0;
    seq_lead  = 8'h00;
  endfunction

  // A gap only counts once something has been written in this text
  function automatic void mark_gap();
    gap_owed = wrote_any;
  endfunction

  // Append one byte to the results of the current step
  function automatic void put_out(input logic [7:0] v);
    step_out.insert(step_out.size(), v);
  endfunction

  function automatic void emit_cp(input logic [20:0] c);
    if (!cp_allowed(c)) begin
      mark_gap();
      return;
    end
    if (gap_owed && !cp_closing(c)) put_out(SPACE_BYTE);
    if (c <= CP_MAX_1B) begin
      put_out(c[7:0]);
    end else if (c <= CP_MAX_2B) begin
      put_out({3'b110, c[10:6]});
      put_out({2'b10, c[5:0]});
    end else if (c <= 21'h00FFFF) begin
      put_out({4'b1110, c[15:12]});
      put_out({2'b10, c[11:6]});
      put_out({2'b10, c[5:0]});
    end else begin
      put_out({5'b11110, c[20:18]});
      put_out({2'b10, c[17:12]});
      put_out({2'b10, c[11:6]});
      put_out({2'b10, c[5:0]});
    end
    gap_owed  = 1'b0;
    wrote_any = 1'b1;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [20:0] c;
    logic [1:0]  n;
    logic        ok;
    if (cont_need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_seen = cont_seen + 2'd1;
        if (cont_seen >= cont_need) begin
          c = cp_acc;
          n = cont_need;
          close_seq();
          case (n)
            2'd1:    ok = c >= CP_MIN_2B;
            2'd2:    ok = c >= CP_MIN_3B && !(c >= SURR_LO && c <= SURR_HI);
            default: ok = c >= CP_MIN_4B && c <= CP_MAX;
          endcase
          if (ok) emit_cp(c);
          else mark_gap();
        end
        return;
      end
      // Broken sequence: drop it and take this byte as a fresh lead
      mark_gap();
      close_seq();
    end
    if (!b[7]) begin
      emit_cp({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      cont_need = 2'd1;
      cp_acc    = {16'd0, b[4:0]};
      seq_lead  = b;
    end else if (b[7:4] == 4'b1110) begin
      cont_need = 2'd2;
      cp_acc    = {17'd0, b[3:0]};
      seq_lead  = b;
    end else if (b[7:3] == 5'b11110) begin
      cont_need = 2'd3;
      cp_acc    = {18'd0, b[2:0]};
      seq_lead  = b;
    end else begin
      mark_gap();
    end
  endfunction

  // Work out the results of one input byte and queue them
  function automatic void sanitize_byte(input logic [7:0] b, input logic last);
    text_result_t r;
    int           k;
    step_out.delete();
    decode_byte(b);
    k = step_out.size();
    if (last && k == 0) begin
      r = '{data: 8'h00, present: 1'b1, run_last: 1'b1, text_end: 1'b1};
      r.present = 1'b0;
      owed_results_q.insert(owed_results_q.size(), r);
      markers_owed++;
    end
    for (int i = 0; i < k; i++) begin
      r = '{data: step_out[i], present: 1'b1, run_last: (i == k - 1),
            text_end: last && (i == k - 1)};
      owed_results_q.insert(owed_results_q.size(), r);
      if (step_out[i] == SPACE_BYTE) spaces_owed++;
    end
    if (last) begin
      gap_owed  = 1'b0;
      wrote_any = 1'b0;
      close_seq();
      texts_done++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int utf8_len(input logic [20:0] c);
    if (c <= CP_MAX_1B) return 1;
    if (c <= CP_MAX_2B) return 2;
    if (c <= 21'h00FFFF) return 3;
    return 4;
  endfunction

  // Encode c in len bytes (longer than needed gives an overlong form) and
  // keep only the first keep of them
  function automatic void add_encoded(input logic [20:0] c, input int len, input int keep);
    logic [7:0] enc[4];
    case (len)
      1: enc[0] = {1'b0, c[6:0]};
      2: begin
        enc[0] = {3'b110, c[10:6]};
        enc[1] = {2'b10, c[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, c[15:12]};
        enc[1] = {2'b10, c[11:6]};
        enc[2] = {2'b10, c[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, c[20:18]};
        enc[1] = {2'b10, c[17:12]};
        enc[2] = {2'b10, c[11:6]};
        enc[3] = {2'b10, c[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) build_q.insert(build_q.size(), enc[i]);
  endfunction

  function automatic logic [20:0] pick_allowed();
    logic [20:0] extras[7];
    extras = '{INV_EXCL, INV_QUEST, LSQUO, RSQUO, LDQUO, RDQUO, ELLIPSIS};
    case ($urandom_range(0, 7))
      0:       return 21'($urandom_range("0", "9"));
      1:       return 21'($urandom_range("A", "Z"));
      2, 3:    return 21'($urandom_range("a", "z"));
      4:       return {13'd0, ALLOWED_PUNCT[$urandom_range(0, ALLOWED_PUNCT.len() - 1)]};
      5:       return 21'($urandom_range(LAT1_LO, LATB_HI));
      6:       return $urandom_range(0, 1) ? 21'($urandom_range(COMB_LO, COMB_HI))
                                           : 21'($urandom_range(LATX_LO, LATX_HI));
      default: return extras[$urandom_range(0, 6)];
    endcase
  endfunction

  function automatic logic [20:0] pick_other();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? 21'(SPACE_BYTE) : 21'($urandom_range(8'h09, 8'h0D));
      1:       return 21'($urandom_range(0, 8'h7F));
      2:       return 21'($urandom_range(21'h000370, CP_MAX_2B));
      3:       return 21'($urandom_range(CP_MIN_3B, 21'h00FFFF));
      default: return 21'($urandom_range(CP_MIN_4B, CP_MAX));
    endcase
  endfunction

  function automatic void queue_built_text();
    text_byte_t t;
    for (int i = 0; i < build_q.size(); i++) begin
      t.data = build_q[i];
      t.last = (i == build_q.size() - 1);
      text_bytes_q.insert(text_bytes_q.size(), t);
    end
    build_q.delete();
  endfunction

  // One random text: mostly valid characters, some damage mixed in
  function automatic void build_text();
    logic [20:0] c;
    int          len;
    int          pick;
    build_q.delete();
    repeat ($urandom_range(1, 14)) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        c = pick_allowed();
        add_encoded(c, utf8_len(c), utf8_len(c));
      end else if (pick < 75) begin
        c = pick_other();
        add_encoded(c, utf8_len(c), utf8_len(c));
      end else if (pick < 81) begin
        build_q.insert(build_q.size(), 8'($urandom_range(0, 255)));
      end else if (pick < 87) begin
        // truncated sequence
        c   = 21'($urandom_range(CP_MIN_2B, CP_MAX));
        len = utf8_len(c);
        add_encoded(c, len, $urandom_range(1, len - 1));
      end else if (pick < 92) begin
        // overlong form
        c   = 21'($urandom_range(0, 21'h00FFFF));
        len = utf8_len(c) + $urandom_range(1, 4 - utf8_len(c));
        add_encoded(c, len, len);
      end else if (pick < 96) begin
        add_encoded(21'($urandom_range(SURR_LO, SURR_HI)), 3, 3);
      end else begin
        add_encoded(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
      end
    end
    queue_built_text();
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: bursts of transfers with random gaps between them
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    text_byte_t item;
    logic       nv;
    logic [7:0] nb;
    logic       nl;
    nv = drv_valid;
    nb = drv_byte;
    nl = drv_last;
    if (drv_valid && in_took) nv = 1'b0;
    if (!rst && !nv) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (text_bytes_q.size() > 0) begin
        item = text_bytes_q.pop_front();
        nv   = 1'b1;
        nb   = item.data;
        nl   = item.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
    drv_valid <= nv;
    drv_byte  <= nb;
    drv_last  <= nl;
  end

  // --------------------------------------------------------------------------
  // Output receiver: stall modes of its own, plus one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    logic nr;
    nr = 1'b0;
    if (!rst) begin
      if (long_hold_left > 0) begin
        long_hold_left--;
      end else if (hold_req && !long_hold_done) begin
        long_hold_left = LONG_HOLD_CYCLES - 1;
        long_hold_done = 1'b1;
      end else begin
        case (rx_mode)
          RX_OPEN:   nr = 1'b1;
          RX_RANDOM: nr = $urandom_range(0, 9) < 6;
          default:   nr = rx_phase < 2;
        endcase
        rx_phase = (rx_phase + 1) % 5;
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_t'($urandom_range(0, 2));
          rx_mode_left = $urandom_range(20, 80);
        end else begin
          rx_mode_left--;
        end
      end
    end
    rcv_ready <= nr;
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input transfers, check output transfers, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    text_result_t got;
    text_result_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        sanitize_byte(in_ch.in_byte, in_ch.text_last);
        bytes_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{data: out_ch.out_byte, present: out_ch.byte_present,
                run_last: out_ch.run_last, text_end: out_ch.text_end};
        results_out++;
        if (owed_results_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("ERROR: unexpected result byte=%02h present=%0b run_last=%0b text_end=%0b",
                     got.data, got.present, got.run_last, got.text_end);
        end else begin
          want = owed_results_q.pop_front();
          if (got.data !== want.data || got.present !== want.present ||
              got.run_last !== want.run_last || got.text_end !== want.text_end) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("ERROR: result %0d byte=%02h/%02h present=%0b/%0b run_last=%0b/%0b %s%0b/%0b",
                       results_out, want.data, got.data, want.present, got.present,
                       want.run_last, got.run_last, "text_end=", want.text_end, got.text_end);
          end
        end
      end
      // Abort if nothing moves for too long
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no transfer for %0d cycles, %0d results still owed",
                   idle_cycles, owed_results_q.size());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] corner_text[] = '{
      8'h00,                      // gap before anything written
      8'h41,                      // plain letter
      8'h20, 8'h2E,               // gap then closing punctuation, no space
      8'h20, 8'h7A,               // gap then letter, space inserted
      8'hC3, 8'hA9,               // two-byte allowed letter
      8'hC0, 8'h80,               // overlong two-byte form
      8'hE2, 8'h80, 8'h99,        // right single quote suppresses the space
      8'hED, 8'hA0, 8'h80,        // surrogate
      8'hE1, 8'hB8, 8'h80,        // space plus three bytes
      8'hF4, 8'h90, 8'h80, 8'h80, // above the codepoint limit
      8'hC3, 8'h41,               // broken sequence, byte retaken as a lead
      8'hBF,                      // stray continuation
      8'hFF,                      // invalid lead
      8'hE2, 8'h80                // sequence still open at text end
    };

    gap_owed  = 1'b0;
    wrote_any = 1'b0;
    close_seq();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corner cases as one text
    foreach (corner_text[i]) build_q.insert(build_q.size(), corner_text[i]);
    queue_built_text();

    // Pause the sender until every owed result has come back
    while (text_bytes_q.size() != 0 || drv_valid || owed_results_q.size() != 0)
      @(posedge clk);

    // Random texts, with the long receiver hold-off while they are offered
    while (text_bytes_q.size() < RANDOM_ITEMS) build_text();
    hold_req = 1'b1;

    while (text_bytes_q.size() != 0 || drv_valid || owed_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (owed_results_q.size() != 0) err_count++;
    $display("Run covered %0d texts, %0d input bytes, %0d result bytes checked",
             texts_done, bytes_in, results_out);
    $display("Including %0d inserted spaces and %0d end markers, %0d mismatches",
             spaces_owed, markers_owed, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/uts_pkg.sv
src/uts_in_if.sv
src/uts_out_if.sv
src/uts_front.sv
src/uts_queue.sv
src/uts_back.sv
src/utf8_text_sanitizer_top.sv
sim/tb_utf8_text_sanitizer_top.sv
